>>> rtl/bbi2c_pkg.sv
package bbi2c_pkg;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned OutDepth = 2;
  localparam int unsigned PhaseW   = 5;

  localparam logic [PhaseW-1:0] StartLast = PhaseW'(3);
  localparam logic [PhaseW-1:0] StopLast  = PhaseW'(2);
  localparam logic [PhaseW-1:0] ByteLast  = PhaseW'(17);
  localparam logic [PhaseW-1:0] AckPhase  = PhaseW'(16);

  localparam logic AckLevel  = 1'b0;
  localparam logic NackLevel = 1'b1;

  typedef enum logic [2:0] {
    ActStart    = 3'd0,
    ActStop     = 3'd1,
    ActWrite    = 3'd2,
    ActReadAck  = 3'd3,
    ActReadNack = 3'd4
  } action_e;

  typedef struct packed {
    action_e    kind;
    logic       first_scl;
    logic [7:0] tx_byte;
    logic [7:0] slave_byte;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_is_input;
    logic [7:0] read_data;
    logic       last_phase;
  } phase_t;

endpackage

>>> rtl/bbi2c_fifo.sv
module bbi2c_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/bbi2c_front.sv
module bbi2c_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [2:0]        action_i,
  input  logic [7:0]        tx_byte_i,
  input  logic [7:0]        slave_byte_i,
  input  logic              cmd_full_i,
  output logic              cmd_push_o,
  output bbi2c_pkg::cmd_t   cmd_o
);

  import bbi2c_pkg::*;

  logic scl_line_q, scl_line_d;
  logic known;
  logic take;

  assign take = push_i && !cmd_full_i;

  always_comb begin
    known      = 1'b1;
    scl_line_d = 1'b0;
    unique case (action_i)
      ActStart:    scl_line_d = 1'b0;
      ActStop:     scl_line_d = 1'b1;
      ActWrite:    scl_line_d = 1'b0;
      ActReadAck:  scl_line_d = 1'b0;
      ActReadNack: scl_line_d = 1'b0;
      default: begin
        known      = 1'b0;
        scl_line_d = scl_line_q;
      end
    endcase
  end

  assign cmd_push_o       = take && known;
  assign cmd_o.kind       = action_e'(action_i);
  assign cmd_o.first_scl  = scl_line_q;
  assign cmd_o.tx_byte    = tx_byte_i;
  assign cmd_o.slave_byte = slave_byte_i;

  // SCL level left by the previous command, in request order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_line_q <= 1'b1;
    end else if (take) begin
      scl_line_q <= scl_line_d;
    end
  end

endmodule

>>> rtl/bbi2c_back.sv
module bbi2c_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_empty_i,
  input  bbi2c_pkg::cmd_t   cmd_i,
  output logic              cmd_pop_o,
  input  logic              out_full_i,
  output logic              out_push_o,
  output bbi2c_pkg::phase_t phase_o
);

  import bbi2c_pkg::*;

  logic              busy_q;
  cmd_t              cmd_q;
  logic [PhaseW-1:0] phase_q;
  logic              emit, is_last, load;
  logic              ack_lvl, tx_bit;

  assign ack_lvl = (cmd_q.kind == ActReadAck) ? AckLevel : NackLevel;
  assign tx_bit  = cmd_q.tx_byte[3'(3'd7 - phase_q[3:1])];

  always_comb begin
    phase_o = '0;
    is_last = 1'b0;
    unique case (cmd_q.kind)
      ActStart: begin
        is_last = (phase_q == StartLast);
        unique case (phase_q[1:0])
          2'd0: begin
            phase_o.scl_level = cmd_q.first_scl;
            phase_o.sda_level = 1'b1;
          end
          2'd1: begin
            phase_o.scl_level = 1'b1;
            phase_o.sda_level = 1'b1;
          end
          2'd2: begin
            phase_o.scl_level = 1'b1;
            phase_o.sda_level = 1'b0;
          end
          default: begin
            phase_o.scl_level = 1'b0;
            phase_o.sda_level = 1'b0;
          end
        endcase
      end
      ActStop: begin
        is_last = (phase_q == StopLast);
        phase_o.scl_level = (phase_q == '0) ? cmd_q.first_scl : 1'b1;
        phase_o.sda_level = is_last;
      end
      ActWrite: begin
        is_last = (phase_q == ByteLast);
        phase_o.scl_level = ~phase_q[0];
        phase_o.sda_level = (phase_q < AckPhase) ? tx_bit : 1'b1;
      end
      default: begin
        is_last = (phase_q == ByteLast);
        if (phase_q < AckPhase) begin
          phase_o.scl_level    = phase_q[0] ? 1'b1 :
                                 ((phase_q == '0) ? cmd_q.first_scl : 1'b0);
          phase_o.sda_level    = 1'b1;
          phase_o.sda_is_input = 1'b1;
        end else begin
          phase_o.scl_level = ~phase_q[0];
          phase_o.sda_level = ack_lvl;
          phase_o.read_data = is_last ? cmd_q.slave_byte : 8'd0;
        end
      end
    endcase
    phase_o.last_phase = is_last;
  end

  assign emit       = busy_q && !out_full_i;
  assign out_push_o = emit;
  assign load       = !cmd_empty_i && (!busy_q || (emit && is_last));
  assign cmd_pop_o  = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= '0;
    end else if (load) begin
      busy_q  <= 1'b1;
      phase_q <= '0;
    end else if (emit && is_last) begin
      busy_q  <= 1'b0;
    end else if (emit) begin
      phase_q <= phase_q + PhaseW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
  end

endmodule

>>> rtl/bitbang_i2c_master_phases.sv
// I2C master line sequencer. Each request on the push side is one command
// (start, stop, write byte, read with ACK, read with NACK) and yields one result
// per line phase on the pop side: start 4 phases, stop 3, byte commands 18.
// The phase sequencer emits one phase per clock while the result queue has room,
// and the next queued command is loaded as the last phase of the current one is
// emitted. A full result queue holds the sequencer on its current phase until a
// result is popped. A small command queue in front and a result queue behind let
// requests be taken while results wait to be popped. Action codes 5 to 7 are
// accepted and dropped without any result. SDA level 1 means released; the read
// byte is given on the last phase of a read and is 0 elsewhere.
module bitbang_i2c_master_phases #(
  parameter int unsigned CmdQDepth = bbi2c_pkg::CmdDepth,
  parameter int unsigned OutQDepth = bbi2c_pkg::OutDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] action_i,
  input  logic [7:0] tx_byte_i,
  input  logic [7:0] slave_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic       sda_is_input_o,
  output logic [7:0] read_data_o,
  output logic       last_phase_o
);

  import bbi2c_pkg::*;

  cmd_t   cmd_in, cmd_out;
  phase_t phase_in, phase_out;
  logic   cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic   out_push, out_full;

  assign full = cmd_full;

  bbi2c_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .action_i     (action_i),
    .tx_byte_i    (tx_byte_i),
    .slave_byte_i (slave_byte_i),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  bbi2c_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdQDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  bbi2c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .phase_o     (phase_in)
  );

  bbi2c_fifo #(
    .Width ($bits(phase_t)),
    .Depth (OutQDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (phase_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (phase_out)
  );

  assign scl_level_o    = phase_out.scl_level;
  assign sda_level_o    = phase_out.sda_level;
  assign sda_is_input_o = phase_out.sda_is_input;
  assign read_data_o    = phase_out.read_data;
  assign last_phase_o   = phase_out.last_phase;

endmodule
